>>> rtl/cmosrtc_pkg.sv
// Shared types, codes and helper functions for the CMOS clock register file.
`default_nettype none

package cmosrtc_pkg;

  localparam int REG_COUNT_DEF     = 64;
  localparam int COUNTER_WIDTH_DEF = 32;

  localparam int IDX_W      = 6;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  // Item kinds carried on s_tuser.
  localparam logic [2:0] MODE_SELECT = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_READ   = 3'd2;
  localparam logic [2:0] MODE_TICK   = 3'd3;
  localparam logic [2:0] MODE_LOAD   = 3'd4;

  // Register indexes with special behavior.
  localparam logic [5:0] REG_SEC      = 6'h00;
  localparam logic [5:0] REG_SEC_ALM  = 6'h01;
  localparam logic [5:0] REG_MIN      = 6'h02;
  localparam logic [5:0] REG_MIN_ALM  = 6'h03;
  localparam logic [5:0] REG_HOUR     = 6'h04;
  localparam logic [5:0] REG_HOUR_ALM = 6'h05;
  localparam logic [5:0] REG_WDAY     = 6'h06;
  localparam logic [5:0] REG_MDAY     = 6'h07;
  localparam logic [5:0] REG_MONTH    = 6'h08;
  localparam logic [5:0] REG_YEAR     = 6'h09;
  localparam logic [5:0] REG_A        = 6'h0a;
  localparam logic [5:0] REG_B        = 6'h0b;
  localparam logic [5:0] REG_C        = 6'h0c;
  localparam logic [5:0] REG_D        = 6'h0d;
  localparam logic [5:0] REG_FLOPPY   = 6'h10;
  localparam logic [5:0] REG_DISK     = 6'h12;
  localparam logic [5:0] REG_BASE_LO  = 6'h15;
  localparam logic [5:0] REG_BASE_HI  = 6'h16;
  localparam logic [5:0] REG_EXT1_HI  = 6'h18;
  localparam logic [5:0] REG_DISK_LO  = 6'h19;
  localparam logic [5:0] REG_DISK_HI  = 6'h2c;
  localparam logic [5:0] REG_EXT2_HI  = 6'h31;
  localparam logic [5:0] REG_CENTURY  = 6'h32;
  localparam logic [5:0] REG_DISK_X0  = 6'h39;
  localparam logic [5:0] REG_DISK_X1  = 6'h3a;

  localparam int UPDATE_SHIFT = 15;  // 32768 ticks per update cycle

  // Fields of one input transaction; the last member sits in the lowest bits.
  typedef struct packed {
    logic       update_busy;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [2:0] weekday;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] load_index;
    logic [7:0] data;
  } in_item_t;

  // Power-up contents of the register file.
  function automatic logic [7:0] reset_value(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      REG_A:       v = 8'h26;
      REG_B:       v = 8'h02;
      REG_D:       v = 8'h80;
      REG_BASE_LO: v = 8'h80;
      REG_BASE_HI: v = 8'h02;
      REG_EXT1_HI: v = 8'hfc;
      REG_EXT2_HI: v = 8'hfc;
      default:     v = 8'h00;
    endcase
    return v;
  endfunction

  // Time value as BCD or binary; v stays below 128.
  function automatic logic [7:0] as_time(input logic [6:0] v, input logic bcd);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    if (bcd) begin
      return {tens, ones[3:0]};
    end
    return {1'b0, v};
  endfunction

endpackage

`default_nettype wire

>>> rtl/cmosrtc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cmosrtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/cmos_rtc_register_file.sv
// Top level of the PC CMOS real-time-clock register file.
`default_nettype none

// This block behaves like the register file of a PC CMOS clock chip. Each
// input transaction is one of: select an index (s_tuser = 0), write the
// selected register (1), read it (2), one 32768 Hz tick (3), or a direct host
// load of any register (4); every transaction yields exactly one result
// transaction carrying the read byte and the periodic interrupt pulse. The
// time of day is supplied with each transaction and reads back in BCD or
// binary as status B bit 2 selects; time registers ignore writes. The block
// takes one transaction per clock cycle while the result side is not stalled,
// through an input register, one pass of decode and update logic, then the
// result register. The register store is a 64-entry RAM whose read address
// is the next selected index, so its registered output belongs to the
// current index, with a one-entry write bypass; per-entry valid bits stand
// in for the power-up contents, so no clearing pass is needed after reset.
// Register C is kept in its own flip-flops. Both sides may stall freely.
module cmos_rtc_register_file
  import cmosrtc_pkg::*;
#(
  parameter int REG_COUNT     = REG_COUNT_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // data[7:0], load_index[13:8], seconds[19:14], minutes[25:20], hours[30:26],
  // weekday[33:31], day_of_month[38:34], month_index[42:39],
  // years_since_1900[50:43], update_busy[51], zero fill above.
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // mode[2:0]
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // read_data[7:0], irq_pulse[8], zero fill above.
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int ADDR_W = $clog2(REG_COUNT);
  localparam int CW     = COUNTER_WIDTH;

  // Input register.
  logic       in_valid;
  logic [2:0] in_mode;
  in_item_t   in_item;

  // Architectural state.
  logic [5:0]    sel;
  logic          bcd_mode;
  logic          periodic_enabled;
  logic [3:0]    rate_select;
  logic          irq_ack;
  logic [7:0]    reg_c;
  logic [CW-1:0] tick_count;
  logic [CW-1:0] last_periodic;
  logic [CW-1:0] last_update;
  logic          valid_bits [REG_COUNT];

  // Write bypass for the RAM's read-old behavior.
  logic             byp_valid;
  logic [ADDR_W-1:0] byp_addr;
  logic [7:0]       byp_data;

  logic [5:0]    sel_next;
  logic          bcd_mode_next;
  logic          periodic_enabled_next;
  logic [3:0]    rate_select_next;
  logic          irq_ack_next;
  logic [7:0]    reg_c_next;
  logic [CW-1:0] tick_count_next;
  logic [CW-1:0] last_periodic_next;
  logic [CW-1:0] last_update_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [ADDR_W-1:0] sel_addr;

  logic       advance;
  logic [7:0] stored;
  logic [7:0] rd_value;
  logic       irq_value;

  logic [3:0]    rate_eff;
  logic [CW-1:0] period_mask;
  logic [CW-1:0] tick_inc;
  logic [CW-1:0] diff_periodic;
  logic [CW-1:0] diff_update;
  logic [1:0]    century;
  logic [7:0]    year_low;

  // A transaction in the input register moves on whenever the result register
  // is empty or being emptied this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_mode <= s_tuser;
      in_item <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    end
  end

  cmosrtc_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(sel_next)),
    .rdata (ram_rdata)
  );

  // The RAM was addressed with this cycle's selected index at the last edge,
  // so its output belongs to sel unless that same edge wrote the entry.
  assign sel_addr = ADDR_W'(sel);
  always_comb begin
    if (byp_valid && byp_addr == sel_addr) begin
      stored = byp_data;
    end else if (valid_bits[sel_addr]) begin
      stored = ram_rdata;
    end else begin
      stored = reset_value(sel);
    end
  end

  // Timer arithmetic: the period is a power of two, so "at least one period
  // elapsed" is any elapsed bit at or above the period's bit.
  assign rate_eff      = (rate_select == 4'd0) ? 4'd1 : rate_select;
  assign period_mask   = (CW'(1) << (rate_eff - 4'd1)) - CW'(1);
  assign tick_inc      = tick_count + CW'(1);
  assign diff_periodic = tick_count - last_periodic;
  assign diff_update   = tick_count - last_update;

  assign century  = (in_item.years_since_1900 >= 8'd200) ? 2'd2 :
                    (in_item.years_since_1900 >= 8'd100) ? 2'd1 : 2'd0;
  assign year_low = in_item.years_since_1900 - 8'(century) * 8'd100;

  always_comb begin
    sel_next              = sel;
    bcd_mode_next         = bcd_mode;
    periodic_enabled_next = periodic_enabled;
    rate_select_next      = rate_select;
    irq_ack_next          = irq_ack;
    reg_c_next            = reg_c;
    tick_count_next       = tick_count;
    last_periodic_next    = last_periodic;
    last_update_next      = last_update;
    ram_we                = 1'b0;
    ram_waddr             = sel_addr;
    ram_wdata             = in_item.data;
    rd_value              = 8'h00;
    irq_value             = 1'b0;

    if (advance) begin
      unique case (in_mode)
        MODE_SELECT: begin
          sel_next = in_item.data[5:0];
        end
        MODE_WRITE: begin
          case (sel) inside
            REG_SEC, REG_MIN, REG_HOUR, REG_WDAY, REG_MDAY, REG_MONTH, REG_YEAR,
            REG_CENTURY: begin
              // Time registers follow the host clock and ignore writes.
            end
            REG_SEC_ALM, REG_MIN_ALM, REG_HOUR_ALM: begin
              ram_we = 1'b1;
            end
            REG_A: begin
              ram_we    = 1'b1;
              ram_wdata = in_item.data & 8'h7f;
              rate_select_next = (in_item.data[3:0] <= 4'd2) ?
                                 in_item.data[3:0] + 4'd7 : in_item.data[3:0];
            end
            REG_B: begin
              ram_we    = 1'b1;
              ram_wdata = in_item.data & 8'h7f;
              bcd_mode_next         = !in_item.data[2];
              periodic_enabled_next = in_item.data[6];
              rate_select_next = (rate_select <= 4'd2) ? rate_select + 4'd7
                                                       : rate_select;
            end
            REG_C: begin
              reg_c_next = in_item.data & 8'h7f;
            end
            REG_D: begin
              ram_we    = 1'b1;
              ram_wdata = in_item.data & 8'h80;
            end
            default: begin
              ram_we    = 1'b1;
              ram_wdata = in_item.data & 8'h7f;
            end
          endcase
        end
        MODE_READ: begin
          case (sel) inside
            REG_SEC:   rd_value = as_time({1'b0, in_item.seconds}, bcd_mode);
            REG_MIN:   rd_value = as_time({1'b0, in_item.minutes}, bcd_mode);
            REG_HOUR:  rd_value = as_time({2'b00, in_item.hours}, bcd_mode);
            REG_WDAY:  rd_value = as_time(7'(in_item.weekday) + 7'd1, bcd_mode);
            REG_MDAY:  rd_value = as_time({2'b00, in_item.day_of_month}, bcd_mode);
            REG_MONTH: rd_value = as_time(7'(in_item.month_index) + 7'd1, bcd_mode);
            REG_YEAR:  rd_value = as_time(year_low[6:0], bcd_mode);
            REG_CENTURY: rd_value = as_time(7'(century) + 7'd19, bcd_mode);
            REG_A: rd_value = {in_item.update_busy, stored[6:0]};
            REG_C: begin
              // Reading status C acknowledges the interrupt. With periodic
              // interrupts off, the flags are derived from elapsed ticks.
              irq_ack_next = 1'b1;
              if (periodic_enabled) begin
                rd_value   = reg_c;
                reg_c_next = 8'h00;
              end else begin
                if ((diff_periodic & ~period_mask) != '0) begin
                  last_periodic_next = tick_count;
                  rd_value[6]        = 1'b1;
                end
                if (diff_update[CW-1:UPDATE_SHIFT] != '0) begin
                  last_update_next = tick_count;
                  rd_value[4]      = 1'b1;
                end
              end
            end
            REG_FLOPPY, REG_DISK, [REG_DISK_LO:REG_DISK_HI], REG_DISK_X0,
            REG_DISK_X1: begin
              rd_value = 8'h00;
            end
            default: rd_value = stored;
          endcase
        end
        MODE_TICK: begin
          tick_count_next = tick_inc;
          if (periodic_enabled && (tick_inc & period_mask) == '0) begin
            reg_c_next = 8'hc0;
            if (irq_ack) begin
              irq_ack_next = 1'b0;
              irq_value    = 1'b1;
            end
          end
        end
        MODE_LOAD: begin
          // Host loads store the byte as is and leave timer state alone.
          if (in_item.load_index == REG_C) begin
            reg_c_next = in_item.data;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(in_item.load_index);
          end
        end
        default: begin
          // Undefined item kinds change nothing.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel              <= REG_D;
      bcd_mode         <= 1'b1;
      periodic_enabled <= 1'b0;
      rate_select      <= 4'd6;
      irq_ack          <= 1'b1;
      reg_c            <= 8'h00;
      tick_count       <= '0;
      last_periodic    <= '0;
      last_update      <= '0;
      byp_valid        <= 1'b0;
      m_tvalid         <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        valid_bits[i] <= 1'b0;
      end
    end else begin
      sel              <= sel_next;
      bcd_mode         <= bcd_mode_next;
      periodic_enabled <= periodic_enabled_next;
      rate_select      <= rate_select_next;
      irq_ack          <= irq_ack_next;
      reg_c            <= reg_c_next;
      tick_count       <= tick_count_next;
      last_periodic    <= last_periodic_next;
      last_update      <= last_update_next;
      byp_valid        <= ram_we;
      if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    byp_addr <= ram_waddr;
    byp_data <= ram_wdata;
    if (advance) begin
      m_tdata <= {{(OUT_DATA_W-9){1'b0}}, irq_value, rd_value};
    end
  end

endmodule

`default_nettype wire
